[hdl/assert_macros.svh]
// Assertion macros used by the deque checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dq assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dq assertion failed");

`endif

[hdl/dq_pkg.sv]
// Package with sizes, operation and status codes, and the cell select and state types of the deque.
package dq_pkg;

    localparam int CAPACITY    = 16;
    localparam int WORD_BITS   = 32;
    localparam int MAX_RESULTS = 16;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Longest dump that is emitted.
    localparam logic [CNT_W-1:0] DUMP_LIMIT =
        CNT_W'((CAPACITY > MAX_RESULTS) ? MAX_RESULTS : CAPACITY);

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_REM_FRONT = 3'd2;
    localparam logic [2:0] OP_REM_BACK  = 3'd3;
    localparam logic [2:0] OP_DUMP      = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_HEAD
    } cell_sel_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } dq_state_t;

endpackage

[hdl/dq_cell.sv]
// One storage cell of the deque chain: holds one word, takes a neighbor's or a new one.
module dq_cell
    import dq_pkg::*;
(
    input  logic                 clk,
    input  cell_sel_t            sel,
    input  logic [WORD_BITS-1:0] load_word,
    input  logic [WORD_BITS-1:0] left,
    input  logic [WORD_BITS-1:0] right,
    input  logic [WORD_BITS-1:0] head,
    output logic [WORD_BITS-1:0] data
);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    always_comb
    begin
        case (sel)
            SEL_LOAD:  data_next = load_word;
            SEL_LEFT:  data_next = left;
            SEL_RIGHT: data_next = right;
            SEL_HEAD:  data_next = head;
            default:   data_next = data_reg;
        endcase
    end

    // Payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[hdl/double_ended_queue.sv]
// Top level of the bounded double-ended queue built as a chain of shifting cells.
//
// The deque holds up to CAPACITY words in a row of cells, the front always in
// cell 0 and the back in cell count-1. An input item carries the operation in
// s_tuser and the word to insert in s_tdata. Insert front shifts the whole
// chain one cell toward the back and drops the new word into cell 0; insert
// back writes the cell just past the back; remove front shifts the chain one
// cell toward the front; remove back only lowers the count. Each of these
// gives one result with tlast set: status OK, EMPTY (remove on an empty
// deque) or FULL (insert refused). A dump rotates the occupied cells toward
// the front once per cycle while the output register is free, emits cell 0
// each step and goes once around the occupied cells, leaving the order unchanged;
// at most MAX_RESULTS entries are emitted, the last one with tlast. A dump of an
// empty deque gives one EMPTY result. Operation codes 5 to 7 are taken and
// ignored. One item is in work at a time; the result sits in an output
// register, so a new item is taken while the previous result waits only if
// that result leaves in the same cycle. Cell contents are undefined after
// reset; only the control registers are cleared, so no clearing pass is needed.
module double_ended_queue
    import dq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word_in
    input  logic [2:0]  s_tuser,   // [2:0] operation
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] word_out
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    dq_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] dump_idx_reg, dump_idx_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [31:0] m_word_reg, m_word_next;
    logic        m_last_reg, m_last_next;

    // Chain moves requested for this cycle.
    logic shift_back;   // every cell takes its front-side neighbor
    logic shift_front;  // every cell takes its back-side neighbor
    logic load_back;    // cell at index count takes the new word
    logic rotate;       // occupied cells move toward the front, head wraps to back

    logic                 slot_free;
    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [CNT_W-1:0]     dump_len;
    logic [WORD_BITS-1:0] new_word;

    logic [WORD_BITS-1:0] cell_data [CAPACITY];
    cell_sel_t            cell_sel  [CAPACITY];

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign dump_len  = (count_reg > DUMP_LIMIT) ? DUMP_LIMIT : count_reg;
    assign new_word  = WORD_BITS'($unsigned(s_tdata));

    // Next state, count and result.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_word_next   = m_word_reg;
        m_last_next   = m_last_reg;
        shift_back    = 1'b0;
        shift_front   = 1'b0;
        load_back     = 1'b0;
        rotate        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Every defined operation reports at least one result.
                    m_word_next = '0;
                    m_last_next = 1'b1;
                    case (s_tuser)
                        OP_INS_FRONT:
                        begin
                            m_valid_next = 1'b1;
                            if (full)
                            begin
                                m_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                m_status_next = STATUS_OK;
                                shift_back    = 1'b1;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        OP_INS_BACK:
                        begin
                            m_valid_next = 1'b1;
                            if (full)
                            begin
                                m_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                m_status_next = STATUS_OK;
                                load_back     = 1'b1;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        OP_REM_FRONT:
                        begin
                            m_valid_next = 1'b1;
                            if (empty)
                            begin
                                m_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                m_status_next = STATUS_OK;
                                shift_front   = 1'b1;
                                count_next    = count_reg - 1'b1;
                            end
                        end
                        OP_REM_BACK:
                        begin
                            m_valid_next = 1'b1;
                            if (empty)
                            begin
                                m_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                m_status_next = STATUS_OK;
                                count_next    = count_reg - 1'b1;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (empty)
                            begin
                                m_valid_next  = 1'b1;
                                m_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // Results come from the dump walk.
                                state_next    = ST_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            // Undefined code: drop the item.
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    rotate        = 1'b1;
                    dump_idx_next = dump_idx_reg + 1'b1;
                    if (dump_idx_reg < dump_len)
                    begin
                        m_valid_next  = 1'b1;
                        m_status_next = STATUS_OK;
                        m_word_next   = 32'($unsigned(cell_data[0]));
                        m_last_next   = (dump_idx_reg == dump_len - 1'b1);
                    end
                    // A full turn of the occupied cells restores the order.
                    if (dump_idx_reg == count_reg - 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Per-cell select and neighbor wiring.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;
        logic                 is_back_slot;
        logic                 is_tail;

        assign is_back_slot = (CNT_W'(i) == count_reg);
        assign is_tail      = (CNT_W'(i + 1) == count_reg);

        if (i == 0)
        begin : g_first
            // The front cell's front-side neighbor is the word being inserted.
            assign left_word = new_word;
        end
        else
        begin : g_inner
            assign left_word = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = cell_data[0];
        end
        else
        begin : g_body
            assign right_word = cell_data[i+1];
        end

        always_comb
        begin
            if (shift_back)
            begin
                cell_sel[i] = SEL_LEFT;
            end
            else if (shift_front)
            begin
                cell_sel[i] = SEL_RIGHT;
            end
            else if (load_back && is_back_slot)
            begin
                cell_sel[i] = SEL_LOAD;
            end
            else if (rotate && is_tail)
            begin
                cell_sel[i] = SEL_HEAD;
            end
            else if (rotate && (CNT_W'(i + 1) < count_reg))
            begin
                cell_sel[i] = SEL_RIGHT;
            end
            else
            begin
                cell_sel[i] = SEL_HOLD;
            end
        end

        dq_cell u_cell (
            .clk       (clk),
            .sel       (cell_sel[i]),
            .load_word (new_word),
            .left      (left_word),
            .right     (right_word),
            .head      (cell_data[0]),
            .data      (cell_data[i])
        );
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        m_status_reg <= m_status_next;
        m_word_reg   <= m_word_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_word_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

[hdl/dq_checker.sv]
// Port-level checker for the deque, bound to the top level.
`include "assert_macros.svh"

module dq_checker
    import dq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A waiting result is not withdrawn.
    `DQ_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

    // Error results carry no word and end their item.
    `DQ_ASSERT_NOW(a_err_clean, m_tvalid && (m_tuser != STATUS_OK), (m_tdata == '0) && m_tlast)

    // Only dump entries are followed by more results of the same item.
    `DQ_ASSERT_NOW(a_mid_ok, m_tvalid && !m_tlast, m_tuser == STATUS_OK)

    // Status is always one of the defined codes.
    `DQ_ASSERT_NOW(a_status_code, m_tvalid,
        (m_tuser == STATUS_OK) || (m_tuser == STATUS_EMPTY) || (m_tuser == STATUS_FULL))

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

[tb/double_ended_queue_tb.sv]
// Self-checking testbench for the bounded double-ended queue, with a ring-buffer predictor.
`timescale 1ns / 100ps

module double_ended_queue_tb;
    import dq_pkg::*;

    // Operation codes that the block takes and drops without any result.
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

    // Cycles with no item moving on either side before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Longest the block can stay busy after its last result (a full dump).
    localparam int TAIL_CYCLES = 2 * MAX_RESULTS + 4;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] word;
        logic        last;
    } deque_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] word_in
    logic [2:0]  s_tuser;   // [2:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] word_out
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;

    // Predicted deque contents: ring of words, front position and fill level.
    logic [31:0]   ring_words [CAPACITY];
    int            ring_head;
    int            ring_fill;

    // Results still owed by the block, oldest first.
    deque_result_t pending_results [$];

    // Idle control for each side; cleared to get stretches at full rate.
    bit sender_idle;
    bit receiver_idle;

    int error_count;
    int item_count;
    int result_count;
    int ignored_count;
    int dump_count;
    int refused_count;
    int empty_count;
    int hang_cycles;

    double_ended_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Queue one expected result and keep the coverage tallies in step.
    function automatic void owe_result(logic [1:0] status, logic [31:0] word, logic last);
        deque_result_t res;
        res.status = status;
        res.word   = word;
        res.last   = last;
        pending_results.push_back(res);
        if (status == STATUS_FULL)
            refused_count++;
        if (status == STATUS_EMPTY)
            empty_count++;
    endfunction

    // Advance the predicted deque by one accepted item and owe its results.
    function automatic void model_item(logic [2:0] op, logic [31:0] word);
        int span;
        case (op)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                if (ring_fill >= CAPACITY)
                    owe_result(STATUS_FULL, '0, 1'b1);
                else
                begin
                    if (op == OP_INS_FRONT)
                    begin
                        ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
                        ring_words[ring_head] = word;
                    end
                    else
                        ring_words[(ring_head + ring_fill) % CAPACITY] = word;
                    ring_fill++;
                    owe_result(STATUS_OK, '0, 1'b1);
                end
            end
            OP_REM_FRONT, OP_REM_BACK:
            begin
                if (ring_fill == 0)
                    owe_result(STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    if (op == OP_REM_FRONT)
                        ring_head = (ring_head + 1) % CAPACITY;
                    ring_fill--;
                    owe_result(STATUS_OK, '0, 1'b1);
                end
            end
            OP_DUMP:
            begin
                dump_count++;
                if (ring_fill == 0)
                    owe_result(STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    span = (ring_fill > MAX_RESULTS) ? MAX_RESULTS : ring_fill;
                    for (int i = 0; i < span; i++)
                        owe_result(STATUS_OK, ring_words[(ring_head + i) % CAPACITY],
                                   i == span - 1);
                end
            end
            default:
                ignored_count++;
        endcase
    endfunction

    // Present one item, hold it until taken, then predict its effect.
    // Leave tvalid high so back-to-back items need no second assignment in one step.
    task automatic send_item(input logic [2:0] op, input logic [31:0] word);
        int gap;
        gap = sender_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        model_item(op, word);
        item_count++;
    endtask

    // Drop tvalid and hold the sender until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mix the extremes in often so the sign and top bits see every corner.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Result side: draw a stall per result, then take it.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = receiver_idle ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Compare each result taken with the oldest one owed, field by field.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result status %0d word %h last %b",
                         $time, m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata !== want.word)
                begin
                    error_count++;
                    $display("%0t: word_out expected %h actual %h",
                             $time, want.word, m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    error_count++;
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    // Hang detector: count cycles in which nothing moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                hang_cycles = 0;
            else
                hang_cycles++;
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, HANG_LIMIT, pending_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Removes and dump on an empty deque: all report empty.
    task automatic test_empty_deque();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        send_item(OP_DUMP, 32'h1234_5678);
        send_item(OP_REM_FRONT, 32'hFFFF_FFFF);
        send_item(OP_REM_BACK, 32'h0000_0000);
    endtask

    // Push the word extremes from both ends, dump them, and check that
    // the reserved codes leave the contents alone.
    task automatic test_word_extremes();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        send_item(OP_INS_FRONT, 32'h8000_0000);
        send_item(OP_INS_BACK, 32'h7FFF_FFFF);
        send_item(OP_INS_FRONT, 32'hFFFF_FFFF);
        send_item(OP_INS_BACK, 32'h0000_0000);
        send_item(OP_DUMP, '0);
        for (logic [3:0] op = 4'(OP_RESERVED_FIRST); op <= 4'(OP_RESERVED_LAST); op++)
            send_item(op[2:0], pick_word());
        send_item(OP_REM_FRONT, '0);
        send_item(OP_REM_BACK, '0);
        send_item(OP_DUMP, '0);
    endtask

    // Fill to capacity, get both inserts refused, dump the whole deque.
    task automatic test_full_deque();
        sender_idle   = 1'b0;
        receiver_idle = 1'b1;
        while (ring_fill < CAPACITY)
            send_item($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK, pick_word());
        send_item(OP_INS_FRONT, pick_word());
        send_item(OP_INS_BACK, pick_word());
        send_item(OP_DUMP, '0);
        wait_drained();
    endtask

    // Random walk of the fill level between empty and full, with dumps and
    // reserved codes sprinkled in; once halfway, pause until drained.
    task automatic test_random_mix(input int count);
        bit growing;
        int pick;
        logic [2:0] op;
        growing = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                sender_idle   = $urandom_range(0, 2) != 0;
                receiver_idle = $urandom_range(0, 2) != 0;
            end
            if (i == count / 2)
                wait_drained();
            // Turn around at the ends, but linger a little to hit full and empty.
            if (ring_fill == CAPACITY && $urandom_range(0, 2) == 0)
                growing = 1'b0;
            if (ring_fill == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
            else if (pick < 14)
                op = OP_DUMP;
            else if ((pick < 70) == growing)
                op = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
            else
                op = $urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_BACK;
            send_item(op, pick_word());
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= OP_DUMP;
        ring_head     = 0;
        ring_fill     = 0;
        error_count   = 0;
        item_count    = 0;
        result_count  = 0;
        ignored_count = 0;
        dump_count    = 0;
        refused_count = 0;
        empty_count   = 0;
        hang_cycles   = 0;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_deque();
        test_word_extremes();
        wait_drained();
        test_full_deque();
        test_random_mix(240);

        // Let any trailing dump or stray result show up before judging.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end

        $display("Ran %0d items (%0d dumps, %0d reserved codes), checked %0d results.",
                 item_count, dump_count, ignored_count, result_count);
        $display("Saw %0d refused inserts and %0d empty reports.", refused_count, empty_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[double_ended_queue.f]
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
tb/double_ended_queue_tb.sv
